/* hdl/tisa_pkg.sv */
`default_nettype none
package tisa_pkg;

  // Operation codes
  localparam logic [4:0] CmdAdd     = 5'd0;
  localparam logic [4:0] CmdSub     = 5'd1;
  localparam logic [4:0] CmdMul     = 5'd2;
  localparam logic [4:0] CmdDiv     = 5'd3;
  localparam logic [4:0] CmdMod     = 5'd4;
  localparam logic [4:0] CmdNeg     = 5'd5;
  localparam logic [4:0] CmdNot     = 5'd6;
  localparam logic [4:0] CmdShl     = 5'd7;
  localparam logic [4:0] CmdShr     = 5'd8;
  localparam logic [4:0] CmdAnd     = 5'd9;
  localparam logic [4:0] CmdOr      = 5'd10;
  localparam logic [4:0] CmdXor     = 5'd11;
  localparam logic [4:0] CmdLnot    = 5'd12;
  localparam logic [4:0] CmdLt      = 5'd13;
  localparam logic [4:0] CmdGt      = 5'd14;
  localparam logic [4:0] CmdLe      = 5'd15;
  localparam logic [4:0] CmdGe      = 5'd16;
  localparam logic [4:0] CmdEq      = 5'd17;
  localparam logic [4:0] CmdNe      = 5'd18;
  localparam logic [4:0] CmdToBool  = 5'd19;
  localparam logic [4:0] CmdToInt64 = 5'd20;

  // Type codes
  localparam logic [3:0] TyU8   = 4'd0;
  localparam logic [3:0] TyI8   = 4'd1;
  localparam logic [3:0] TyChar = 4'd2;
  localparam logic [3:0] TyU16  = 4'd3;
  localparam logic [3:0] TyI16  = 4'd4;
  localparam logic [3:0] TyU32  = 4'd5;
  localparam logic [3:0] TyI32  = 4'd6;
  localparam logic [3:0] TyU64  = 4'd7;
  localparam logic [3:0] TyI64  = 4'd8;
  localparam logic [3:0] TyBool = 4'd9;

  // Error codes
  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrDivZero = 2'd1;
  localparam logic [1:0] ErrType    = 2'd2;

  // One divider step per quotient bit
  localparam int unsigned DivSteps = 64;

  typedef struct packed {
    logic [4:0]  command;
    logic [3:0]  type_code;
    logic [63:0] left_operand;
    logic [63:0] right_operand;
  } in_t;

  typedef struct packed {
    logic [63:0] result;
    logic [1:0]  error_code;
  } out_t;

  // Control and partial result carried beside the datapath
  typedef struct packed {
    logic        use_mul;
    logic        use_q;
    logic        use_r;
    logic        neg_q;
    logic        neg_r;
    logic [1:0]  err;
    logic [63:0] mask;
    logic [63:0] res;
  } side_t;

  function automatic logic [63:0] type_mask(input logic [3:0] ty);
    logic [63:0] m;
    case (ty)
      TyU16, TyI16: m = 64'h0000_0000_0000_ffff;
      TyU32, TyI32: m = 64'h0000_0000_ffff_ffff;
      TyU64, TyI64: m = 64'hffff_ffff_ffff_ffff;
      default:      m = 64'h0000_0000_0000_00ff;
    endcase
    return m;
  endfunction

  function automatic logic type_signed(input logic [3:0] ty);
    return (ty == TyI8) || (ty == TyI16) || (ty == TyI32) || (ty == TyI64);
  endfunction

  function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [3:0] ty);
    logic [63:0] r;
    case (ty)
      TyU16, TyI16: r = {{48{v[15]}}, v[15:0]};
      TyU32, TyI32: r = {{32{v[31]}}, v[31:0]};
      TyU64, TyI64: r = v;
      default:      r = {{56{v[7]}}, v[7:0]};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/tisa_prep.sv */
`default_nettype none
// Decode, operand reduction, simple results and multiply (two stages)
module tisa_prep (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  wire tisa_pkg::in_t  in_i,
  output logic                vld_o,
  output tisa_pkg::side_t     side_o,
  output logic [63:0]         dvd_o,
  output logic [63:0]         dvs_o
);

  logic [63:0] a, b, m, am, bm, sa, sb, ka, kb, ua, ub;
  logic        sg, isbool, tyok, na, nb, brej;
  tisa_pkg::side_t s1_d;
  tisa_pkg::side_t s1_q;
  logic [63:0] p0_q, p1_q, p2_q, dvd_q, dvs_q;
  logic        v1_q, v2_q;
  tisa_pkg::side_t s2_d;
  tisa_pkg::side_t s2_q;
  logic [63:0] dvd2_q, dvs2_q;

  // Stage 1 decode
  always_comb begin
    a      = in_i.left_operand;
    b      = in_i.right_operand;
    tyok   = in_i.type_code <= tisa_pkg::TyBool;
    m      = tisa_pkg::type_mask(in_i.type_code);
    sg     = tisa_pkg::type_signed(in_i.type_code);
    isbool = in_i.type_code == tisa_pkg::TyBool;
    am     = a & m;
    bm     = b & m;
    sa     = sg ? tisa_pkg::sign_ext(a, in_i.type_code) : am;
    sb     = sg ? tisa_pkg::sign_ext(b, in_i.type_code) : bm;
    ka     = sg ? {~sa[63], sa[62:0]} : am;
    kb     = sg ? {~sb[63], sb[62:0]} : bm;
    na     = sg & sa[63];
    nb     = sg & sb[63];
    ua     = na ? 64'd0 - sa : sa;
    ub     = nb ? 64'd0 - sb : sb;
    brej   = 1'b0;

    s1_d         = '0;
    s1_d.mask    = m;
    s1_d.err     = tisa_pkg::ErrNone;
    s1_d.neg_q   = na ^ nb;
    s1_d.neg_r   = na;
    case (in_i.command)
      tisa_pkg::CmdAdd: begin s1_d.res = a + b; brej = 1'b1; end
      tisa_pkg::CmdSub: begin s1_d.res = a - b; brej = 1'b1; end
      tisa_pkg::CmdMul: begin s1_d.use_mul = 1'b1; brej = 1'b1; end
      tisa_pkg::CmdDiv, tisa_pkg::CmdMod: begin
        s1_d.use_q = in_i.command == tisa_pkg::CmdDiv;
        s1_d.use_r = in_i.command == tisa_pkg::CmdMod;
        if (bm == 64'd0) begin
          s1_d.err = tisa_pkg::ErrDivZero;
        end else begin
          brej = 1'b1;
        end
      end
      tisa_pkg::CmdNeg:  begin s1_d.res = 64'd0 - a; brej = 1'b1; end
      tisa_pkg::CmdNot:  s1_d.res = ~a;
      tisa_pkg::CmdShl:  s1_d.res = (b[63:6] != 58'd0) ? 64'd0 : (a << b[5:0]);
      tisa_pkg::CmdShr:  s1_d.res = (b[63:6] != 58'd0) ? 64'd0 : (am >> b[5:0]);
      tisa_pkg::CmdAnd:  s1_d.res = a & b;
      tisa_pkg::CmdOr:   s1_d.res = a | b;
      tisa_pkg::CmdXor:  s1_d.res = a ^ b;
      tisa_pkg::CmdLnot: s1_d.res = {63'd0, am == 64'd0};
      tisa_pkg::CmdLt:   begin s1_d.res = {63'd0, ka < kb};  brej = 1'b1; end
      tisa_pkg::CmdGt:   begin s1_d.res = {63'd0, ka > kb};  brej = 1'b1; end
      tisa_pkg::CmdLe:   begin s1_d.res = {63'd0, ka <= kb}; brej = 1'b1; end
      tisa_pkg::CmdGe:   begin s1_d.res = {63'd0, ka >= kb}; brej = 1'b1; end
      tisa_pkg::CmdEq:   s1_d.res = {63'd0, am == bm};
      tisa_pkg::CmdNe:   s1_d.res = {63'd0, am != bm};
      tisa_pkg::CmdToBool: begin
        s1_d.res  = {63'd0, a != 64'd0};
        s1_d.mask = '1;
      end
      tisa_pkg::CmdToInt64: begin
        s1_d.res  = isbool ? {63'd0, am != 64'd0} : sa;
        s1_d.mask = '1;
      end
      default: s1_d.err = tisa_pkg::ErrType;
    endcase
    if (brej && isbool) s1_d.err = tisa_pkg::ErrType;
    if (!tyok) s1_d.err = tisa_pkg::ErrType;
  end

  // Stage 1 registers: side, operands and low-64-bit partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      p0_q  <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
      p1_q  <= 64'(a[31:0] * b[63:32]);
      p2_q  <= 64'(a[63:32] * b[31:0]);
      dvd_q <= ua;
      dvs_q <= ub;
    end
  end

  // Stage 2: fold partial products
  always_comb begin
    s2_d = s1_q;
    if (s1_q.use_mul) begin
      s2_d.res = p0_q + {p1_q[31:0] + p2_q[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q     <= s2_d;
      dvd2_q   <= dvd_q;
      dvs2_q   <= dvs_q;
    end
  end

  assign vld_o  = v2_q;
  assign side_o = s2_q;
  assign dvd_o  = dvd2_q;
  assign dvs_o  = dvs2_q;

endmodule
`default_nettype wire

/* hdl/tisa_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per pipeline stage
module tisa_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            vld_i,
  input  wire tisa_pkg::side_t side_i,
  input  wire logic [63:0]     dvd_i,
  input  wire logic [63:0]     dvs_i,
  output logic                 vld_o,
  output tisa_pkg::side_t      side_o,
  output logic [63:0]          quo_o,
  output logic [63:0]          rem_o
);

  localparam int unsigned N = tisa_pkg::DivSteps;

  logic            vld_q  [N];
  tisa_pkg::side_t side_q [N];
  logic [63:0]     rem_q  [N];
  logic [63:0]     quo_q  [N];
  logic [63:0]     dvs_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic            v_in;
    tisa_pkg::side_t s_in;
    logic [63:0]     r_in, q_in, d_in;
    logic [64:0]     sh, df;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in = vld_i;
      assign s_in = side_i;
      assign r_in = 64'd0;
      assign q_in = dvd_i;
      assign d_in = dvs_i;
    end else begin : g_next
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = dvs_q[k-1];
    end

    // trial subtract of the shifted partial remainder
    assign sh = {r_in, q_in[63]};
    assign df = sh - {1'b0, d_in};
    assign ge = !df[64];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
        rem_q[k]  <= ge ? df[63:0] : sh[63:0];
        quo_q[k]  <= {q_in[62:0], ge};
        dvs_q[k]  <= d_in;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign side_o = side_q[N-1];
  assign quo_o  = quo_q[N-1];
  assign rem_o  = rem_q[N-1];

endmodule
`default_nettype wire

/* hdl/typed_integer_stack_alu_core.sv */
`default_nettype none
// Typed integer ALU for a stack interpreter.
// Input channel: in_valid_i / in_ready_o with in_data_i (command, type code,
// two 64-bit operands). Output channel: out_valid_o / out_ready_i with
// out_data_o (result masked to the type width, error code).
// Every transaction gives exactly one result, in order.
// The path from acceptance to out_valid_o has two decode/multiply
// stages, 64 divider stages (one quotient bit each) and a result stage.
// Throughput: one transaction per cycle unless stalled; every operation
// walks the full pipeline, so the divider stage count sets the latency.
// The whole pipeline advances together. When the output register holds a
// result that the receiver does not take, all stages hold and in_ready_o
// drops; holes in the pipeline are still filled while out_valid_o is low.
// Reset clears all valid bits and the input-enable flag live_q; the
// block is ready in the cycle after reset is released.
module typed_integer_stack_alu_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire tisa_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output tisa_pkg::out_t      out_data_o
);

  logic            en;
  logic            live_q;
  logic            pv;
  tisa_pkg::side_t ps;
  logic [63:0]     pdvd, pdvs;
  logic            dv;
  tisa_pkg::side_t ds;
  logic [63:0]     dq, dr;
  logic [63:0]     val;
  logic            out_vld_q;
  tisa_pkg::out_t  out_d;
  tisa_pkg::out_t  out_q;

  // input opens the cycle after reset release
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else begin
      live_q <= 1'b1;
    end
  end

  // global advance
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en && live_q;

  tisa_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i && live_q),
    .in_i   (in_data_i),
    .vld_o  (pv),
    .side_o (ps),
    .dvd_o  (pdvd),
    .dvs_o  (pdvs)
  );

  tisa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pv),
    .side_i (ps),
    .dvd_i  (pdvd),
    .dvs_i  (pdvs),
    .vld_o  (dv),
    .side_o (ds),
    .quo_o  (dq),
    .rem_o  (dr)
  );

  // sign fixup and result select
  always_comb begin
    if (ds.use_q) begin
      val = ds.neg_q ? 64'd0 - dq : dq;
    end else if (ds.use_r) begin
      val = ds.neg_r ? 64'd0 - dr : dr;
    end else begin
      val = ds.res;
    end
  end

  // final masking; errors force a zero result
  always_comb begin
    out_d.error_code = ds.err;
    out_d.result     = (ds.err != tisa_pkg::ErrNone) ? 64'd0 : (val & ds.mask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // an error always comes with a zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.error_code != tisa_pkg::ErrNone)
      |-> out_data_o.result == 64'd0)
    else $error("nonzero result with error");

  // error code stays within its defined codes
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.error_code != 2'd3)
    else $error("undefined error code");

  // a stalled output blocks new transactions
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during output stall");
`endif

endmodule
`default_nettype wire
